### design/nds_pkg.sv
// Package for the note duration segmenter: transaction payload types,
// controller/datapath command and status types, command codes and the pitch table.
// Depends on nothing.
package nds_pkg;

   localparam logic [1:0] CMD_NOP = 2'd0;
   localparam logic [1:0] CMD_OFF = 2'd1;
   localparam logic [1:0] CMD_ON  = 2'd2;
   localparam logic [1:0] CMD_END = 2'd3;

   localparam int         CNT_W       = 4;
   localparam logic [3:0] MAX_RESULTS = 4'd8;

   typedef struct packed {
      logic [1:0] command;
      logic [3:0] octave;
      logic [5:0] degree;
   } nds_req_type;

   typedef struct packed {
      logic       is_note;
      logic       tie_before;
      logic [3:0] note_octave;
      logic [5:0] note_degree;
      logic       pitch_known;
      logic [4:0] seg_ticks;
      logic       beam_break;
      logic       last;
   } nds_rsp_type;

   typedef struct packed {
      logic accept;
      logic seg_step;
      logic apply;
      logic wrap;
      logic finish;
   } nds_ctl_type;

   typedef struct packed {
      logic cmd_flush;
      logic span_nz;
      logic bar_end;
      logic step_ok;
      logic held_v;
      logic out_free;
   } nds_status_type;

   function automatic logic pitch_named(input logic [5:0] d);
      logic named;
      case (d)
         6'd0, 6'd7, 6'd8, 6'd9, 6'd14, 6'd17, 6'd18, 6'd21, 6'd22,
         6'd27, 6'd31, 6'd34, 6'd36, 6'd39, 6'd40, 6'd48, 6'd49: begin
            named = 1'b1;
         end
         default: begin
            named = 1'b0;
         end
      endcase
      return named;
   endfunction

endpackage

### design/note_duration_segmenter.sv
// Note duration segmenter top level: joins the controller and the datapath.
// A transaction is accepted, flushes segments, applies the command and advances
// the tick, flushes and wraps at the bar end, then releases the held segment.
// One transaction at a time; segment output can stall on back-pressure.
// Synchronous active-high reset clears the note state and tick position to zero.
// Depends on nds_pkg, nds_controller and nds_datapath.
module note_duration_segmenter #(
   parameter int BAR_TICKS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  nds_pkg::nds_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output nds_pkg::nds_rsp_type rsp_data
);

   nds_pkg::nds_ctl_type    ctl;
   nds_pkg::nds_status_type sts;

   nds_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   nds_datapath #(
      .BAR_TICKS (BAR_TICKS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### design/nds_datapath.sv
// Datapath of the note duration segmenter: note state, tick position, segment
// length logic, one-deep hold register and the output register.
// Depends on nds_pkg.
module nds_datapath #(
   parameter int BAR_TICKS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  nds_pkg::nds_req_type   req_data,
   input  nds_pkg::nds_ctl_type   ctl,
   output nds_pkg::nds_status_type sts,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output nds_pkg::nds_rsp_type   rsp_data
);

   localparam int            PW      = $clog2(BAR_TICKS + 1);
   localparam logic [PW-1:0] BAR_END = PW'(BAR_TICKS);

   nds_pkg::nds_req_type in_ff, in_in;
   logic                 sounding_ff, sounding_in;
   logic                 tie_pending_ff, tie_pending_in;
   logic [3:0]           held_octave_ff, held_octave_in;
   logic [5:0]           held_degree_ff, held_degree_in;
   logic [PW-1:0]        start_ff, start_in;
   logic [PW-1:0]        tick_ff, tick_in;
   logic [nds_pkg::CNT_W-1:0] count_ff, count_in;
   logic                 hold_v_ff, hold_v_in;
   nds_pkg::nds_rsp_type hold_ff, hold_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   nds_pkg::nds_rsp_type rsp_ff, rsp_in;

   logic [PW-1:0]        span;
   logic [PW-1:0]        len_sel;
   logic [PW+4:0]        len_wide;
   logic [PW-1:0]        seg_end;
   nds_pkg::nds_rsp_type seg;
   logic                 report;
   logic                 out_free;
   logic                 push_out;
   nds_pkg::nds_rsp_type push_data;

   assign span = tick_ff - start_ff;

   always_comb begin
      logic ok;
      len_sel = '0;
      for (int k = 0; k < PW; k++) begin
         ok = ((span >> k) != '0);
         for (int b = 0; b < k; b++) begin
            if (start_ff[b]) begin
               ok = 1'b0;
            end
         end
         if (ok) begin
            len_sel = {{(PW-1){1'b0}}, 1'b1} << k;
         end
      end
   end

   assign len_wide = {5'b0, len_sel};
   assign seg_end  = start_ff + len_sel;

   always_comb begin
      seg.is_note     = sounding_ff;
      seg.tie_before  = sounding_ff & tie_pending_ff;
      seg.note_octave = sounding_ff ? held_octave_ff : 4'd0;
      seg.note_degree = sounding_ff ? held_degree_ff : 6'd0;
      seg.pitch_known = sounding_ff & nds_pkg::pitch_named(held_degree_ff);
      seg.seg_ticks   = len_wide[4:0];
      seg.beam_break  = (seg_end[1:0] == 2'b00);
      seg.last        = 1'b0;
   end

   assign report   = (count_ff < nds_pkg::MAX_RESULTS);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (in_ff.command)
         nds_pkg::CMD_OFF: begin
            sts.cmd_flush = sounding_ff;
         end
         nds_pkg::CMD_ON, nds_pkg::CMD_END: begin
            sts.cmd_flush = 1'b1;
         end
         default: begin
            sts.cmd_flush = 1'b0;
         end
      endcase
      sts.span_nz  = (start_ff < tick_ff);
      sts.bar_end  = (tick_ff == BAR_END);
      sts.step_ok  = !report || !hold_v_ff || out_free;
      sts.held_v   = hold_v_ff;
      sts.out_free = out_free;
   end

   always_comb begin
      in_in          = in_ff;
      sounding_in    = sounding_ff;
      tie_pending_in = tie_pending_ff;
      held_octave_in = held_octave_ff;
      held_degree_in = held_degree_ff;
      start_in       = start_ff;
      tick_in        = tick_ff;
      count_in       = count_ff;
      hold_v_in      = hold_v_ff;
      hold_in        = hold_ff;
      push_out       = 1'b0;
      push_data      = hold_ff;

      if (ctl.accept) begin
         in_in    = req_data;
         count_in = '0;
      end

      if (ctl.seg_step) begin
         start_in       = seg_end;
         tie_pending_in = 1'b1;
         if (report) begin
            count_in  = count_ff + 1'b1;
            hold_in   = seg;
            hold_v_in = 1'b1;
            push_out  = hold_v_ff;
         end
      end

      if (ctl.apply) begin
         case (in_ff.command)
            nds_pkg::CMD_OFF: begin
               if (sounding_ff) begin
                  sounding_in    = 1'b0;
                  tie_pending_in = 1'b0;
               end
            end
            nds_pkg::CMD_ON: begin
               sounding_in    = 1'b1;
               tie_pending_in = 1'b0;
               held_octave_in = in_ff.octave;
               held_degree_in = in_ff.degree;
               start_in       = tick_ff;
            end
            default: begin
            end
         endcase
         if (in_ff.command != nds_pkg::CMD_END) begin
            tick_in = tick_ff + 1'b1;
         end
      end

      if (ctl.wrap) begin
         tick_in  = '0;
         start_in = '0;
      end

      if (ctl.finish) begin
         push_out       = 1'b1;
         push_data.last = 1'b1;
         hold_v_in      = 1'b0;
      end

      rsp_in = rsp_ff;
      if (push_out) begin
         rsp_valid_in = 1'b1;
         rsp_in       = push_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sounding_ff    <= 1'b0;
         tie_pending_ff <= 1'b0;
         held_octave_ff <= '0;
         held_degree_ff <= '0;
         start_ff       <= '0;
         tick_ff        <= '0;
         count_ff       <= '0;
         hold_v_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         sounding_ff    <= sounding_in;
         tie_pending_ff <= tie_pending_in;
         held_octave_ff <= held_octave_in;
         held_degree_ff <= held_degree_in;
         start_ff       <= start_in;
         tick_ff        <= tick_in;
         count_ff       <= count_in;
         hold_v_ff      <= hold_v_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff   <= in_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### design/nds_controller.sv
// Controller of the note duration segmenter: sequences the command flush,
// the tick advance, the bar wrap flush and the release of the final segment.
// Depends on nds_pkg.
module nds_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  nds_pkg::nds_status_type sts,
   output nds_pkg::nds_ctl_type    ctl
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CMD    = 5'b00010,
      ST_ADV    = 5'b00100,
      ST_WRAP   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.accept = 1'b1;
               state_in   = ST_CMD;
            end
         end
         ST_CMD: begin
            if (sts.cmd_flush && sts.span_nz) begin
               ctl.seg_step = sts.step_ok;
            end else begin
               ctl.apply = 1'b1;
               state_in  = ST_ADV;
            end
         end
         ST_ADV: begin
            state_in = sts.bar_end ? ST_WRAP : ST_FINISH;
         end
         ST_WRAP: begin
            if (sts.span_nz) begin
               ctl.seg_step = sts.step_ok;
            end else begin
               ctl.wrap = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!sts.held_v) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule
